>>> hw/rtl/spq_pkg.sv
// Package for the stable minimum priority queue.
// Holds the command, result and entry types and the opcode and status codes.
// No dependencies.
package spq_pkg;

    localparam int TAG_W  = 16;
    localparam int PRIO_W = 8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_REMOVED  = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic              opcode;
        logic [TAG_W-1:0]  entry_tag;
        logic [PRIO_W-1:0] priority_req;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [TAG_W-1:0]  served_tag;
        logic [PRIO_W-1:0] served_priority;
    } res_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic insert_en;
        logic remove_en;
    } cell_ctl_t;

endpackage

>>> hw/rtl/stable_min_priority_queue.sv
// Top level of the stable minimum priority queue.
// Instantiates a chain of spq_cell; depends on spq_pkg.
//
//   channel   ports                     transfer
//   -------   -----------------------   -------------------------------
//   command   start, busy, cmd          start high and busy low at edge
//   result    done, result              done high for one cycle, taken
//
// Each command is first registered, then executed: every cell of the chain
// shifts or holds at once. The result appears on result with done in the
// cycle after the execute cycle, and a new command may be transferred in
// that same cycle. busy is high in the execute cycle only, so no new
// command is taken while one executes, independent of fill level.
// Reset clears the fill count and the handshake flags; cell contents are
// not reset. The receiver cannot stall: a result is shown for one cycle.
//
// The chain is kept sorted by priority, and in arrival order among equal
// priorities, so cell 0 always holds the entry to serve next.
module stable_min_priority_queue
    import spq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic done,
    output res_t result
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    logic             cmd_valid_reg;
    cmd_t             cmd_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             done_reg;
    res_t             result_reg;
    res_t             result_next;

    logic       is_full;
    logic       is_empty;
    cell_ctl_t  ctl;
    entry_t     new_entry;

    entry_t cell_entry [QUEUE_DEPTH];
    logic   cell_flag  [QUEUE_DEPTH];

    // Latch the command on transfer; execute it in the next cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= start && !cmd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !cmd_valid_reg)
        begin
            cmd_reg <= cmd;
        end
    end

    assign busy = cmd_valid_reg;

    assign is_full  = (count_reg == DEPTH_CNT);
    assign is_empty = (count_reg == '0);

    // Drop an insert when full; a remove on empty touches nothing.
    assign ctl.insert_en = cmd_valid_reg && (cmd_reg.opcode == OP_INSERT) && !is_full;
    assign ctl.remove_en = cmd_valid_reg && (cmd_reg.opcode == OP_REMOVE) && !is_empty;

    assign new_entry.tag  = cmd_reg.entry_tag;
    assign new_entry.prio = cmd_reg.priority_req;

    // Cell chain: every cell sees the new entry and both neighbors.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic   left_flag;
        entry_t left_entry;
        entry_t right_entry;

        if (i == 0)
        begin : g_head
            assign left_flag  = 1'b0;
            assign left_entry = new_entry;
        end
        else
        begin : g_body
            assign left_flag  = cell_flag[i-1];
            assign left_entry = cell_entry[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .new_entry   (new_entry),
            .valid       (count_reg > CNT_W'(i)),
            .left_flag   (left_flag),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .flag        (cell_flag[i])
        );
    end

    // Advance the fill count and build the result for the executing command.
    always_comb
    begin
        count_next  = count_reg;
        result_next = '0;
        if (cmd_reg.opcode == OP_INSERT)
        begin
            result_next.status = is_full ? ST_FULL : ST_INSERTED;
        end
        else
        begin
            result_next.status = is_empty ? ST_EMPTY : ST_REMOVED;
        end
        if (ctl.insert_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctl.remove_en)
        begin
            count_next                  = count_reg - 1'b1;
            result_next.served_tag      = cell_entry[0].tag;
            result_next.served_priority = cell_entry[0].prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Fill count never passes the chain length.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("fill count beyond queue depth");

    // The execute stage never runs in consecutive cycles.
    a_busy_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held for two cycles");

    // A removal shrinks the count by one.
    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == ST_REMOVED) |-> count_reg == $past(count_reg) - 1'b1)
        else $error("removal did not shrink the count");

    // The head of the chain is never larger than its neighbor.
    if (QUEUE_DEPTH > 1)
    begin : g_sorted_chk
        a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
            (count_reg > CNT_W'(1)) |-> cell_entry[0].prio <= cell_entry[1].prio)
            else $error("queue head out of order");
    end

endmodule

>>> hw/rtl/spq_cell.sv
// One cell of the sorted queue chain: holds a single entry.
// Depends on spq_pkg.
module spq_cell
    import spq_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  entry_t    new_entry,
    input  logic      valid,
    input  logic      left_flag,
    input  entry_t    left_entry,
    input  entry_t    right_entry,
    output entry_t    entry,
    output logic      flag
);

    entry_t entry_reg;
    entry_t entry_next;

    // The new entry belongs at or before this cell if the cell is empty or
    // holds a strictly larger priority; equal priorities keep arrival order.
    assign flag = !valid || (new_entry.prio < entry_reg.prio);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.remove_en)
        begin
            entry_next = right_entry;
        end
        else if (ctl.insert_en && flag)
        begin
            entry_next = left_flag ? left_entry : new_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
